// ----- rtl/hcbp_pkg.sv -----
// Shared types, request codes and constants for the Huffman code bit packer.
package hcbp_pkg;

    localparam int SYMBOL_COUNT_DEF = 128;
    localparam int MAX_CODE_LEN     = 32;
    localparam int WORD_BITS        = 32;
    localparam int BYTE_BITS        = 8;
    localparam int LEN_W            = 6;
    localparam int WIN_W            = WORD_BITS + BYTE_BITS;
    localparam int CNT_W            = 6;

    // Saturation limit for a loaded code length
    localparam int LEN_CAP = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [6:0]           symbol;
        logic [LEN_W-1:0]     code_length;
        logic [WORD_BITS-1:0] code_bits;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]     len;
        logic [WORD_BITS-1:0] bits;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic align;
        logic merge;
        logic emit;
        logic commit;
        logic flush;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sym_ok;
        logic pend_nz;
        logic cnt_ge8;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/hcbp_ctrl.sv -----
// Sequencing state machine for the Huffman code bit packer.
module hcbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_req_type,
    input  hcbp_pkg::t_sts    i_sts,
    output logic              o_in_ready,
    output hcbp_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALIGN = 5'b00010,
        S_MERGE = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        hcbp_pkg::REQ_LOAD: begin
                            o_cmd.load = i_sts.sym_ok;
                        end
                        hcbp_pkg::REQ_ENCODE: begin
                            if (i_sts.sym_ok) begin
                                o_cmd.lookup = 1'b1;
                                n_state      = S_ALIGN;
                            end
                        end
                        hcbp_pkg::REQ_FLUSH: begin
                            if (i_sts.pend_nz) begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: begin
                            // drop unknown requests
                        end
                    endcase
                end
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state     = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.cnt_ge8) begin
                    // keep the leftover bits as the new partial byte
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/hcbp_dpath.sv -----
// Code table memory, bit window, partial byte and output register.
module hcbp_dpath #(
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hcbp_pkg::t_in_item  i_in_item,
    input  hcbp_pkg::t_cmd      i_cmd,
    input  logic                i_out_ready,
    output hcbp_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output hcbp_pkg::t_out_item o_out_item
);

    localparam int IW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);
    localparam logic [hcbp_pkg::LEN_W-1:0] LEN_MAX = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP);
    localparam int BB = hcbp_pkg::BYTE_BITS;
    localparam int WB = hcbp_pkg::WORD_BITS;
    localparam int WW = hcbp_pkg::WIN_W;
    localparam int CW = hcbp_pkg::CNT_W;

    hcbp_pkg::t_entry r_mem [SYMBOL_COUNT];
    hcbp_pkg::t_entry r_rd;

    logic [8:0]                  sym_ext;
    logic [IW-1:0]               idx;
    logic [hcbp_pkg::LEN_W-1:0]  len_cap;

    logic [WB-1:0]               r_code_l;
    logic [hcbp_pkg::LEN_W-1:0]  r_len;
    logic [WW-1:0]               r_win;
    logic [CW-1:0]               r_cnt;

    logic [BB-1:0]               r_acc;
    logic [2:0]                  r_pend;
    logic                        r_out_valid;
    hcbp_pkg::t_out_item         r_out;

    logic [BB-1:0]               n_acc;
    logic [2:0]                  n_pend;
    logic                        n_out_valid;
    hcbp_pkg::t_out_item         n_out;
    logic                        out_free;

    assign sym_ext = {2'b00, i_in_item.symbol};
    assign idx     = sym_ext[IW-1:0];
    assign len_cap = (i_in_item.code_length > LEN_MAX) ? LEN_MAX : i_in_item.code_length;

    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.sym_ok   = (sym_ext < SYM_LIMIT);
    assign o_sts.pend_nz  = (r_pend != 3'd0);
    assign o_sts.cnt_ge8  = (r_cnt >= CW'(BB));
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Code table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[idx] <= '{len: len_cap, bits: i_in_item.code_bits};
        end
        if (i_cmd.lookup) begin
            r_rd <= r_mem[idx];
        end
    end

    // Left-align the code, then place it right after the pending bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.align) begin
            r_code_l <= r_rd.bits << (hcbp_pkg::LEN_W'(WB) - r_rd.len);
            r_len    <= r_rd.len;
        end
        if (i_cmd.merge) begin
            r_win <= {r_acc, {WB{1'b0}}} | ({r_code_l, {BB{1'b0}}} >> r_pend);
            r_cnt <= CW'(r_pend) + CW'(r_len);
        end else if (i_cmd.emit) begin
            r_win <= r_win << BB;
            r_cnt <= r_cnt - CW'(BB);
        end
    end

    always_comb begin
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit) begin
            n_out.out_byte = r_win[WW-1 -: BB];
            n_out.last     = (r_cnt < CW'(2 * BB));
            n_out_valid    = 1'b1;
        end else if (i_cmd.flush) begin
            // partial byte is kept left-aligned, so the padding is already zero
            n_out.out_byte = r_acc;
            n_out.last     = 1'b1;
            n_out_valid    = 1'b1;
            n_acc          = '0;
            n_pend         = '0;
        end
        if (i_cmd.commit) begin
            n_acc  = r_win[WW-1 -: BB];
            n_pend = r_cnt[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ----- rtl/huffman_code_bit_packer.sv -----
// Huffman encoder back end: code table and MSB-first byte packer.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_item) takes one
// request per handshake: load a table entry, encode a symbol, or flush.
// Output channel (o_out_valid / i_out_ready, payload o_out_item) carries
// packed bytes, earliest bit in the MSB; last marks the final byte of
// the request that produced it.
// A load gives no byte. An encode gives n output bytes (0 to 4):
// table read, code alignment, window merge, then one byte per cycle
// from the window while the output register is free, then a step to
// keep the leftover bits. A flush with pending bits gives one padded
// byte. The single output register sets the byte rate, one per cycle
// while the receiver is ready to take each byte.
// Reset (synchronous, active low) clears the partial byte and the output
// valid flag; table entries hold no reset value and must be loaded first.
// When the receiver stalls, the byte in the output register holds and
// the packer waits; a new request is taken only after the last byte of
// the current one has entered the output register.
module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hcbp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hcbp_pkg::t_out_item o_out_item
);

    hcbp_pkg::t_cmd cmd;
    hcbp_pkg::t_sts sts;

    hcbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    hcbp_dpath #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- rtl/hcbp_chk.sv -----
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_chk #(
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input hcbp_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hcbp_pkg::t_out_item o_out_item
);

    localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // Stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output byte changed while stalled");

    // Nothing pending right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An encode of a table symbol keeps the packer busy for the next cycle
    a_enc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.req_type == hcbp_pkg::REQ_ENCODE
         && {2'b00, i_in_item.symbol} < SYM_LIMIT) |=> !o_in_ready)
        else $error("request taken while encode in progress");

    // A table load never produces a byte
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.req_type == hcbp_pkg::REQ_LOAD && !o_out_valid)
        |=> !o_out_valid)
        else $error("byte produced by a table load");

endmodule

bind huffman_code_bit_packer hcbp_chk #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
) u_hcbp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- test/tb_huffman_code_bit_packer.sv -----
// Self-checking testbench for the Huffman code bit packer: table loads, encodes, flushes.
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         REPORT_MAX   = 10;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    hcbp_pkg::t_in_item  in_item  = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    hcbp_pkg::t_out_item out_item;

    huffman_code_bit_packer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Predicted packer state
    logic [hcbp_pkg::LEN_W-1:0]     code_len_q  [hcbp_pkg::SYMBOL_COUNT_DEF];
    logic [hcbp_pkg::WORD_BITS-1:0] code_word_q [hcbp_pkg::SYMBOL_COUNT_DEF];
    logic [7:0]                     acc_bits;
    int                             acc_count;
    hcbp_pkg::t_out_item            byte_q [$];

    // Request stream and the symbols it has already loaded
    hcbp_pkg::t_in_item pending [$];
    bit                 gen_loaded [hcbp_pkg::SYMBOL_COUNT_DEF];
    int                 gen_syms [$];

    int  send_idle_pct = 18;
    int  recv_idle_pct = 51;
    int  phase         = 0;
    int  errors        = 0;
    int  reqs_done     = 0;
    int  bytes_checked = 0;
    int  encodes_done  = 0;
    int  flushes_done  = 0;
    int  stall_cycles  = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic pack_request(input hcbp_pkg::t_in_item req);
        hcbp_pkg::t_out_item            held;
        bit                             have_held;
        int                             len;
        logic [hcbp_pkg::WORD_BITS-1:0] code;
        have_held = 1'b0;
        case (req.req_type)
            hcbp_pkg::REQ_LOAD: begin
                code_len_q[req.symbol]  = (req.code_length > hcbp_pkg::LEN_CAP)
                                          ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP)
                                          : req.code_length;
                code_word_q[req.symbol] = req.code_bits;
            end
            hcbp_pkg::REQ_ENCODE: begin
                encodes_done++;
                len  = code_len_q[req.symbol];
                code = code_word_q[req.symbol];
                for (int i = len; i > 0; i--) begin
                    acc_bits = {acc_bits[6:0], code[i-1]};
                    acc_count++;
                    if (acc_count == hcbp_pkg::BYTE_BITS) begin
                        // hold each byte back until we know whether it closes the request
                        if (have_held) byte_q.push_back(held);
                        held      = '{out_byte: acc_bits, last: 1'b0};
                        have_held = 1'b1;
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    byte_q.push_back(held);
                end
            end
            hcbp_pkg::REQ_FLUSH: begin
                flushes_done++;
                if (acc_count != 0) begin
                    byte_q.push_back('{out_byte: acc_bits << (hcbp_pkg::BYTE_BITS - acc_count),
                                       last: 1'b1});
                    acc_bits  = '0;
                    acc_count = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_load(input int sym, input int len, input logic [31:0] bits);
        hcbp_pkg::t_in_item r;
        r = '{req_type: hcbp_pkg::REQ_LOAD, symbol: 7'(sym), code_length: 6'(len),
              code_bits: bits};
        pending.push_back(r);
        if (!gen_loaded[sym]) begin
            gen_loaded[sym] = 1'b1;
            gen_syms.push_back(sym);
        end
    endtask

    task automatic add_request(input logic [1:0] kind, input int sym);
        hcbp_pkg::t_in_item r;
        r = '{req_type: kind, symbol: 7'(sym), code_length: 6'($urandom_range(63)),
              code_bits: $urandom()};
        pending.push_back(r);
    endtask

    task automatic add_random(input int count);
        int pick;
        int len_pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 20 || gen_syms.size() == 0) begin
                len_pick = $urandom_range(99);
                add_load($urandom_range(hcbp_pkg::SYMBOL_COUNT_DEF - 1),
                         (len_pick < 5)  ? 0 :
                         (len_pick < 15) ? $urandom_range(63, 33) : $urandom_range(32, 1),
                         $urandom());
            end else if (pick < 82) begin
                add_request(hcbp_pkg::REQ_ENCODE,
                            gen_syms[$urandom_range(gen_syms.size() - 1)]);
            end else if (pick < 94) begin
                add_request(hcbp_pkg::REQ_FLUSH,
                            $urandom_range(hcbp_pkg::SYMBOL_COUNT_DEF - 1));
            end else begin
                add_request(REQ_UNUSED, $urandom_range(hcbp_pkg::SYMBOL_COUNT_DEF - 1));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || byte_q.size() != 0) @(posedge clk);
    endtask

    // Request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                pack_request(in_item);
                reqs_done++;
            end
            if (!in_valid || in_ready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_item  <= pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor and receiver
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (byte_q.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("unexpected byte %02h last %0b", out_item.out_byte,
                                 out_item.last);
                end else begin
                    hcbp_pkg::t_out_item want;
                    want = byte_q.pop_front();
                    bytes_checked++;
                    if (out_item.out_byte !== want.out_byte || out_item.last !== want.last)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                     want.out_byte, want.last, out_item.out_byte,
                                     out_item.last);
                    end
                end
            end
            // one long hold-off while requests keep coming, so the input backs up
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (phase == 2 && !hold_done && in_valid) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        acc_bits  = '0;
        acc_count = 0;

        // Directed: table extremes, saturation, empty codes, flush corners, unused request
        add_load(0, 0, 32'hFFFF_FFFF);
        add_load(127, 32, 32'hFFFF_FFFF);
        add_load(1, 63, 32'h8000_0001);
        add_load(2, 1, 32'hFFFF_FFFF);
        add_load(3, 7, 32'h0000_0055);
        add_load(4, 33, 32'h0000_0000);
        add_request(hcbp_pkg::REQ_ENCODE, 0);
        add_request(hcbp_pkg::REQ_ENCODE, 2);
        add_request(hcbp_pkg::REQ_FLUSH, 0);
        add_request(hcbp_pkg::REQ_FLUSH, 127);
        add_request(hcbp_pkg::REQ_ENCODE, 3);
        add_request(hcbp_pkg::REQ_ENCODE, 2);
        add_request(hcbp_pkg::REQ_ENCODE, 127);
        add_request(hcbp_pkg::REQ_ENCODE, 1);
        add_request(hcbp_pkg::REQ_ENCODE, 3);
        add_request(hcbp_pkg::REQ_ENCODE, 127);
        add_request(hcbp_pkg::REQ_ENCODE, 4);
        add_request(REQ_UNUSED, 5);
        add_request(hcbp_pkg::REQ_FLUSH, 0);
        add_load(0, 5, 32'h0000_0015);
        add_request(hcbp_pkg::REQ_ENCODE, 0);
        add_request(hcbp_pkg::REQ_FLUSH, 0);

        add_random(26);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        send_idle_pct = 51;
        recv_idle_pct = 18;
        phase         = 1;
        add_random(26);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = 2;
        add_random(25);
        add_request(hcbp_pkg::REQ_FLUSH, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (byte_q.size() != 0) begin
            errors++;
            $display("%0d expected bytes never arrived", byte_q.size());
        end
        $display("covered %0d requests (%0d encodes, %0d flushes), %0d bytes checked",
                 reqs_done, encodes_done, flushes_done, bytes_checked);
        $display("three idling mixes plus one %0d-cycle receiver hold, %0d errors",
                 LONG_HOLD, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
